FILE: rtl/core/labsr_pkg.sv
// Shared types and constants of the lidar angle bin store.
package labsr_pkg;

    localparam int NUM_BINS        = 360;
    localparam int BIN_W           = 9;
    localparam int TURN_UNITS      = NUM_BINS * 64;
    localparam int DEF_HALF_WINDOW = 5;

    localparam int RANGE_W = 16;
    localparam int TIME_W  = 16;
    localparam int ANGLE_W = 15;
    localparam int HEAD_W  = 16;

    // Input tdata layout, lowest bit first.
    localparam int PANG_LSB   = 0;
    localparam int HEAD_LSB   = 15;
    localparam int PRANGE_LSB = 31;
    localparam int QDEG_LSB   = 47;
    localparam int NOW_LSB    = 56;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 16;

    localparam logic [15:0] RST_MIN_RANGE = 16'd100;
    localparam logic [15:0] RST_MAX_RANGE = 16'd3000;
    localparam logic [15:0] RST_MAX_AGE   = 16'd800;
    localparam logic [15:0] RST_TOLERANCE = 16'd50;

    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        REG_MIN_RANGE = 2'd0,
        REG_MAX_RANGE = 2'd1,
        REG_MAX_AGE   = 2'd2,
        REG_TOLERANCE = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] min_range;
        logic [RANGE_W-1:0] max_range;
        logic [TIME_W-1:0]  max_age;
        logic [RANGE_W-1:0] tolerance;
    } cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range;
        logic [TIME_W-1:0]  stamp;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic             we;
        logic [BIN_W-1:0] addr;
        entry_t           wdata;
    } mem_req_t;

endpackage

FILE: rtl/core/lidar_angle_bin_store_robust_read.sv
// Top level of the lidar angle bin store: configuration registers and wiring.
//
// A store request (tuser 0) maps the point angle, corrected by the heading, to
// one of 360 whole-degree bins and writes range and timestamp there, or zeros
// when the range is not strictly inside the configured limits, and gives no
// result. A query request (tuser 1) reads the 2*HALF_WINDOW bins from
// query_degree-HALF_WINDOW upward, one memory read per bin on the single memory
// port, and then loads its result into the output register; a result waiting
// at the output delays only the end of the next query. After reset the memory
// is cleared one bin a cycle, during which s_tready stays low; configuration
// writes are taken at any time and are always ready.
module lidar_angle_bin_store_robust_read #(
    parameter int HALF_WINDOW = labsr_pkg::DEF_HALF_WINDOW
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // point_angle[14:0], heading[30:15], point_range[46:31],
    // query_degree[55:47], now_ms[71:56]
    input  logic [labsr_pkg::IN_DATA_W-1:0]  s_tdata,
    // command
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // range_mm[15:0]
    output logic [labsr_pkg::OUT_DATA_W-1:0] m_tdata,
    // found
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [15:0]                      cfg_data
);
    import labsr_pkg::*;

    cfg_t             cfg_reg, cfg_next;
    mem_req_t         mem_req;
    entry_t           rd_data;
    logic [BIN_W-1:0] bin;
    logic             in_load;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_MIN_RANGE: cfg_next.min_range = cfg_data;
                REG_MAX_RANGE: cfg_next.max_range = cfg_data;
                REG_MAX_AGE:   cfg_next.max_age   = cfg_data;
                REG_TOLERANCE: cfg_next.tolerance = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_range <= RST_MIN_RANGE;
            cfg_reg.max_range <= RST_MAX_RANGE;
            cfg_reg.max_age   <= RST_MAX_AGE;
            cfg_reg.tolerance <= RST_TOLERANCE;
        end
        else
            cfg_reg <= cfg_next;
    end

    assign in_load = s_tvalid && s_tready;

    labsr_bin_map u_bin_map (
        .clk         (clk),
        .load        (in_load),
        .point_angle (s_tdata[PANG_LSB +: ANGLE_W]),
        .heading     ($signed(s_tdata[HEAD_LSB +: HEAD_W])),
        .bin         (bin)
    );

    labsr_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    labsr_ctrl #(
        .HALF_WINDOW (HALF_WINDOW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .bin      (bin),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .mem_req  (mem_req),
        .rd_data  (rd_data)
    );

endmodule

FILE: rtl/core/labsr_mem.sv
// Bin store memory: one range and timestamp per bin, registered read data.
module labsr_mem (
    input  logic                clk,
    input  labsr_pkg::mem_req_t req,
    output labsr_pkg::entry_t   rd_data
);
    import labsr_pkg::*;

    entry_t mem_q [NUM_BINS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
                mem_q[req.addr] <= req.wdata;
            else
                rd_data_reg <= mem_q[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/labsr_bin_map.sv
// Angle to bin mapping: heading correction (registered), turn wrap and rounding.
module labsr_bin_map (
    input  logic                                clk,
    input  logic                                load,
    input  logic [labsr_pkg::ANGLE_W-1:0]       point_angle,
    input  logic signed [labsr_pkg::HEAD_W-1:0] heading,
    output logic [labsr_pkg::BIN_W-1:0]         bin
);
    import labsr_pkg::*;

    localparam logic signed [17:0] OFFSET = 18'(2 * TURN_UNITS);
    localparam logic [16:0] T1 = 17'(TURN_UNITS);
    localparam logic [16:0] T2 = 17'(2 * TURN_UNITS);
    localparam logic [16:0] T3 = 17'(3 * TURN_UNITS);
    localparam logic [16:0] T4 = 17'(4 * TURN_UNITS);

    logic signed [17:0] shifted;
    logic [16:0]        x_reg;
    logic [16:0]        sub;
    logic [14:0]        a;
    logic [14:0]        rounded;
    logic [BIN_W-1:0]   b;

    // Two turns added keeps the difference positive for any input.
    assign shifted = $signed({3'b000, point_angle}) + OFFSET - 18'(heading);

    always_ff @(posedge clk)
    begin
        if (load)
            x_reg <= shifted[16:0];
    end

    always_comb
    begin
        if (x_reg >= T4)
            sub = T4;
        else if (x_reg >= T3)
            sub = T3;
        else if (x_reg >= T2)
            sub = T2;
        else if (x_reg >= T1)
            sub = T1;
        else
            sub = '0;
        a       = 15'(x_reg - sub);
        rounded = a + 15'd32;
        b       = rounded[14:6];
        bin     = (b == BIN_W'(NUM_BINS)) ? '0 : b;
    end

endmodule

FILE: rtl/core/labsr_ctrl.sv
// Sequencer: memory clear, store writes, window scan and result register.
module labsr_ctrl #(
    parameter int HALF_WINDOW = labsr_pkg::DEF_HALF_WINDOW
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  labsr_pkg::cfg_t                      cfg,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [labsr_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                 s_tuser,
    input  logic [labsr_pkg::BIN_W-1:0]          bin,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [labsr_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                 m_tuser,
    output labsr_pkg::mem_req_t                  mem_req,
    input  labsr_pkg::entry_t                    rd_data
);
    import labsr_pkg::*;

    localparam int CNT_W = $clog2(2 * HALF_WINDOW + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(2 * HALF_WINDOW - 1);
    localparam logic [BIN_W:0]   HW       = (BIN_W + 1)'(HALF_WINDOW);
    localparam logic [BIN_W:0]   NB       = (BIN_W + 1)'(NUM_BINS);
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MAP   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_TAIL  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [BIN_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [BIN_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic               have_prev_reg, have_prev_next;
    logic               found_reg, found_next;
    logic               m_valid_reg, m_valid_next;

    logic [RANGE_W-1:0] range_reg, range_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [RANGE_W-1:0] prev_reg, prev_next;
    logic [RANGE_W-1:0] result_reg, result_next;
    logic               m_found_reg, m_found_next;
    logic [RANGE_W-1:0] m_range_reg, m_range_next;

    logic [BIN_W-1:0]   qdeg;
    logic [BIN_W:0]     q_mod;
    logic [BIN_W:0]     start;
    logic [TIME_W-1:0]  age;
    logic               kept;
    logic [RANGE_W-1:0] diff;
    logic [RANGE_W-1:0] smaller;

    assign qdeg  = s_tdata[QDEG_LSB +: BIN_W];
    assign q_mod = ({1'b0, qdeg} >= NB) ? ({1'b0, qdeg} - NB) : {1'b0, qdeg};
    assign start = (q_mod < HW) ? (q_mod + NB - HW) : (q_mod - HW);

    assign age     = now_reg - rd_data.stamp;
    assign kept    = (rd_data.range != '0) && (age < cfg.max_age);
    assign diff    = (rd_data.range > prev_reg) ? (rd_data.range - prev_reg)
                                                : (prev_reg - rd_data.range);
    assign smaller = (rd_data.range < prev_reg) ? rd_data.range : prev_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        scan_idx_next  = scan_idx_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        have_prev_next = have_prev_reg;
        found_next     = found_reg;
        m_valid_next   = m_valid_reg;
        range_next     = range_reg;
        now_next       = now_reg;
        prev_next      = prev_reg;
        result_next    = result_reg;
        m_found_next   = m_found_reg;
        m_range_next   = m_range_reg;
        mem_req        = '0;

        if (m_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_req.en   = 1'b1;
                mem_req.we   = 1'b1;
                mem_req.addr = clr_idx_reg;
                if (clr_idx_reg == LAST_BIN)
                    state_next = S_IDLE;
                else
                    clr_idx_next = clr_idx_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    range_next = s_tdata[PRANGE_LSB +: RANGE_W];
                    now_next   = s_tdata[NOW_LSB +: TIME_W];
                    if (s_tuser == CMD_QUERY)
                    begin
                        scan_idx_next  = start[BIN_W-1:0];
                        cnt_next       = '0;
                        pend_next      = 1'b0;
                        have_prev_next = 1'b0;
                        found_next     = 1'b0;
                        result_next    = '0;
                        state_next     = S_SCAN;
                    end
                    else
                        state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                mem_req.en   = 1'b1;
                mem_req.we   = 1'b1;
                mem_req.addr = bin;
                if (range_reg > cfg.min_range && range_reg < cfg.max_range)
                begin
                    mem_req.wdata.range = range_reg;
                    mem_req.wdata.stamp = now_reg;
                end
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                mem_req.en    = 1'b1;
                mem_req.addr  = scan_idx_reg;
                scan_idx_next = (scan_idx_reg == LAST_BIN) ? '0 : scan_idx_reg + 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                pend_next     = 1'b1;
                if (cnt_reg == LAST_CNT)
                    state_next = S_TAIL;
            end
            S_TAIL:
            begin
                pend_next  = 1'b0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    m_range_next = result_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Data read in the previous cycle; the first agreeing pair freezes the result.
        if (pend_reg && !found_reg && kept)
        begin
            if (have_prev_reg && diff < cfg.tolerance)
            begin
                found_next  = 1'b1;
                result_next = smaller;
            end
            prev_next      = rd_data.range;
            have_prev_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            scan_idx_reg  <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
            found_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            scan_idx_reg  <= scan_idx_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            have_prev_reg <= have_prev_next;
            found_reg     <= found_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        range_reg   <= range_next;
        now_reg     <= now_next;
        prev_reg    <= prev_next;
        result_reg  <= result_next;
        m_found_reg <= m_found_next;
        m_range_reg <= m_range_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = m_range_reg;

endmodule

FILE: bench/lidar_angle_bin_store_robust_read_tb.sv
// Testbench for the lidar angle bin store: directed table, then clustered random traffic.
module lidar_angle_bin_store_robust_read_tb;
    import labsr_pkg::*;

    localparam int HALF_WIN       = DEF_HALF_WINDOW;
    localparam int SETTLE_CYCLES  = 2 * HALF_WIN + 8;
    localparam int NUM_PHASES     = 7;
    localparam int RAND_PER_PHASE = 275;
    localparam int NUM_DIR_ROWS   = 24;
    localparam bit TYPED          = 1'b1;
    localparam bit PREDICTED      = 1'b0;

    typedef struct packed {
        logic         cmd;
        logic [14:0]  angle;
        logic [15:0]  heading;
        logic [15:0]  point_range;
        logic [8:0]   qdeg;
        logic [15:0]  now;
    } lidar_req_t;

    typedef struct packed {
        logic         found;
        logic [15:0]  range_mm;
    } read_result_t;

    typedef struct packed {
        logic         cmd;
        logic [14:0]  angle;
        logic [15:0]  heading;
        logic [15:0]  point_range;
        logic [8:0]   qdeg;
        logic [15:0]  now;
        logic         typed;
        logic         exp_found;
        logic [15:0]  exp_range;
    } dir_row_t;

    // typed rows assume the reset register values (100, 3000, 800, 50)
    dir_row_t dir_rows [NUM_DIR_ROWS] = '{
        '{CMD_QUERY, 15'd0,     16'd0,       16'd0,     9'd0,   16'd0,     TYPED, 1'b0, 16'd0},
        '{CMD_QUERY, 15'd0,     16'd0,       16'd0,     9'd511, 16'd65535, TYPED, 1'b0, 16'd0},
        '{CMD_STORE, 15'd0,     16'd0,       16'd1000,  9'd0,   16'd100,   PREDICTED, 1'b0, 16'd0},
        '{CMD_STORE, 15'd64,    16'd0,       16'd1010,  9'd0,   16'd100,   PREDICTED, 1'b0, 16'd0},
        '{CMD_QUERY, 15'd0,     16'd0,       16'd0,     9'd0,   16'd200,   TYPED, 1'b1, 16'd1000},
        // wraps to a full turn, lands in bin 0; range equal to min clears
        '{CMD_STORE, 15'd23039, 16'hA600,    16'd100,   9'd0,   16'd7,     PREDICTED, 1'b0, 16'd0},
        '{CMD_QUERY, 15'd0,     16'd0,       16'd0,     9'd0,   16'd200,   TYPED, 1'b0, 16'd0},
        '{CMD_STORE, 15'd31,    16'd0,       16'd3000,  9'd0,   16'd5,     PREDICTED, 1'b0, 16'd0},
        '{CMD_STORE, 15'd0,     16'd23040,   16'd2999,  9'd0,   16'd65530, PREDICTED, 1'b0, 16'd0},
        '{CMD_STORE, 15'd32,    16'd0,       16'd2990,  9'd0,   16'd65530, PREDICTED, 1'b0, 16'd0},
        // window wraps past 359, age wraps past 2^16
        '{CMD_QUERY, 15'd0,     16'd0,       16'd0,     9'd359, 16'd10,    TYPED, 1'b1, 16'd2990},
        '{CMD_QUERY, 15'd0,     16'd0,       16'd0,     9'd6,   16'd10,    TYPED, 1'b0, 16'd0},
        '{CMD_QUERY, 15'd0,     16'd0,       16'd0,     9'd356, 16'd10,    TYPED, 1'b0, 16'd0},
        '{CMD_QUERY, 15'd0,     16'd0,       16'd0,     9'd5,   16'd793,   TYPED, 1'b1, 16'd2990},
        '{CMD_QUERY, 15'd0,     16'd0,       16'd0,     9'd5,   16'd794,   TYPED, 1'b0, 16'd0},
        '{CMD_STORE, 15'd1280,  16'd0,       16'd500,   9'd0,   16'd1000,  PREDICTED, 1'b0, 16'd0},
        '{CMD_STORE, 15'd1344,  16'd0,       16'd550,   9'd0,   16'd1000,  PREDICTED, 1'b0, 16'd0},
        // difference equal to tolerance does not match
        '{CMD_QUERY, 15'd0,     16'd0,       16'd0,     9'd20,  16'd1000,  TYPED, 1'b0, 16'd0},
        '{CMD_STORE, 15'd1408,  16'd0,       16'd549,   9'd0,   16'd1000,  PREDICTED, 1'b0, 16'd0},
        '{CMD_QUERY, 15'd0,     16'd0,       16'd0,     9'd21,  16'd1000,  TYPED, 1'b1, 16'd549},
        '{CMD_STORE, 15'd32767, 16'h8000,    16'd65535, 9'd0,   16'd65535, PREDICTED, 1'b0, 16'd0},
        '{CMD_STORE, 15'd640,   16'h7FFF,    16'd0,     9'd0,   16'd0,     PREDICTED, 1'b0, 16'd0},
        '{CMD_QUERY, 15'd0,     16'd0,       16'd0,     9'd304, 16'd0,     PREDICTED, 1'b0, 16'd0},
        '{CMD_QUERY, 15'd0,     16'd0,       16'd0,     9'd218, 16'd0,     PREDICTED, 1'b0, 16'd0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [1:0]             cfg_index;
    logic [15:0]            cfg_data;

    lidar_angle_bin_store_robust_read DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the bin stores and registers
    logic [15:0]    shadow_range [NUM_BINS];
    logic [15:0]    shadow_stamp [NUM_BINS];
    cfg_t           cfg_shadow;
    read_result_t   expected_reads [$];
    bit             failed;

    int             burst_left;
    logic [15:0]    clock_ms;
    int             focus_deg;
    int             base_range;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int wrap_deg(input int d);
        d = d % NUM_BINS;
        if (d < 0)
            d += NUM_BINS;
        return d;
    endfunction

    function automatic int point_bin(input logic [14:0] angle, input logic [15:0] heading);
        int d;
        int b;
        d = int'(angle) - int'($signed(heading));
        d = d % TURN_UNITS;
        if (d < 0)
            d += TURN_UNITS;
        b = (d + 32) >> 6;
        if (b >= NUM_BINS)
            b = 0;
        return b;
    endfunction

    // updates the shadow bins for a store; works out the read result for a query
    function automatic void apply_request(input lidar_req_t r, output read_result_t res);
        int          b;
        int          idx;
        logic [15:0] prev;
        logic [15:0] cur;
        logic [15:0] age;
        logic [15:0] diff;
        bit          have_prev;
        res = '0;
        if (r.cmd == CMD_STORE)
        begin
            b = point_bin(r.angle, r.heading);
            if (r.point_range > cfg_shadow.min_range && r.point_range < cfg_shadow.max_range)
            begin
                shadow_range[b] = r.point_range;
                shadow_stamp[b] = r.now;
            end
            else
            begin
                shadow_range[b] = '0;
                shadow_stamp[b] = '0;
            end
            return;
        end
        have_prev = 1'b0;
        prev = '0;
        for (int off = -HALF_WIN; off < HALF_WIN && !res.found; off++)
        begin
            idx = wrap_deg(int'(r.qdeg) % NUM_BINS + off);
            cur = shadow_range[idx];
            age = r.now - shadow_stamp[idx];
            if (cur == 0 || age >= cfg_shadow.max_age)
                continue;
            if (have_prev)
            begin
                diff = (cur > prev) ? cur - prev : prev - cur;
                if (diff < cfg_shadow.tolerance)
                begin
                    res.found = 1'b1;
                    res.range_mm = (cur < prev) ? cur : prev;
                end
            end
            prev = cur;
            have_prev = 1'b1;
        end
    endfunction

    task automatic send_request(input lidar_req_t r, input bit typed, input read_result_t typed_res);
        read_result_t res;
        int           gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tuser  = r.cmd;
        s_tdata  = {r.now, r.qdeg, r.point_range, r.heading, r.angle};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_request(r, res);
        if (r.cmd == CMD_QUERY)
            expected_reads.push_back(typed ? typed_res : res);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MIN_RANGE: cfg_shadow.min_range = val;
            REG_MAX_RANGE: cfg_shadow.max_range = val;
            REG_MAX_AGE:   cfg_shadow.max_age   = val;
            REG_TOLERANCE: cfg_shadow.tolerance = val;
            default: ;
        endcase
    endtask

    // drain every outstanding read and let a trailing store finish
    task automatic settle_block();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic pick_base_range();
        int lo;
        int hi;
        lo = int'(cfg_shadow.min_range) + 1;
        hi = int'(cfg_shadow.max_range) - 1;
        base_range = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(0, 65535);
    endtask

    // mostly stores and queries clustered around one focus degree, some pure noise
    task automatic build_request(output lidar_req_t r);
        int b;
        int hd;
        int a;
        int spread;
        int t;
        if ($urandom_range(0, 29) == 0)
        begin
            focus_deg = $urandom_range(0, NUM_BINS - 1);
            pick_base_range();
        end
        clock_ms += 16'($urandom_range(0, 40));
        if ($urandom_range(0, 49) == 0)
            clock_ms = 16'($urandom);
        if ($urandom_range(0, 4) == 0)
        begin
            r = lidar_req_t'({$urandom, $urandom, $urandom});
            return;
        end
        r = '0;
        r.now = clock_ms;
        if ($urandom_range(0, 9) < 6)
        begin
            r.cmd = CMD_STORE;
            b = wrap_deg(focus_deg + int'($urandom_range(0, 13)) - 7);
            hd = int'($urandom_range(0, 2 * TURN_UNITS)) - TURN_UNITS;
            a = (b * 64 + int'($urandom_range(0, 63)) - 32 + hd) % TURN_UNITS;
            if (a < 0)
                a += TURN_UNITS;
            if (a < 32768 - TURN_UNITS && $urandom_range(0, 7) == 0)
                a += TURN_UNITS;
            r.angle = a[14:0];
            r.heading = hd[15:0];
            if ($urandom_range(0, 9) == 0)
                r.point_range = $urandom_range(0, 1) ? cfg_shadow.min_range
                                                     : cfg_shadow.max_range;
            else
            begin
                spread = (cfg_shadow.tolerance == 0) ? 4 : int'(cfg_shadow.tolerance) * 3 / 2;
                if (spread > 2000)
                    spread = 2000;
                r.point_range = 16'(base_range + $urandom_range(0, spread));
            end
        end
        else
        begin
            r.cmd = CMD_QUERY;
            t = wrap_deg(focus_deg + int'($urandom_range(0, 10)) - 5);
            if (t < 512 - NUM_BINS && $urandom_range(0, 5) == 0)
                t += NUM_BINS;
            r.qdeg = t[8:0];
        end
    endtask

    // receiver: random stall pattern, plus two long hold-offs
    initial
    begin
        int          cyc;
        int          hold_left;
        logic [7:0]  stall_bits;
        cyc = 0;
        hold_left = 0;
        stall_bits = 8'hFF;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc == 4000 || cyc == 16000)
                hold_left = 600;
            if (cyc % 64 == 0)
                stall_bits = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready = 1'b0;
            end
            else
                m_tready = stall_bits[cyc % 8];
        end
    end

    always @(posedge clk)
    begin
        read_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_reads.size() == 0)
            begin
                $error("unexpected result: found %0d range_mm %0d", m_tuser, m_tdata);
                failed = 1'b1;
            end
            else
            begin
                want = expected_reads.pop_front();
                if (m_tuser !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, m_tuser);
                    failed = 1'b1;
                end
                if (m_tdata !== want.range_mm)
                begin
                    $error("range_mm: expected %0d, actual %0d", want.range_mm, m_tdata);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        lidar_req_t   req;
        read_result_t typed_res;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_STORE;
        cfg_valid = 1'b0;
        cfg_index = REG_MIN_RANGE;
        cfg_data  = '0;
        rst_n     = 1'b0;
        failed    = 1'b0;
        burst_left = 0;
        clock_ms  = '0;
        focus_deg = 0;
        for (int i = 0; i < NUM_BINS; i++)
        begin
            shadow_range[i] = '0;
            shadow_stamp[i] = '0;
        end
        cfg_shadow = '{RST_MIN_RANGE, RST_MAX_RANGE, RST_MAX_AGE, RST_TOLERANCE};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            req = '{dir_rows[i].cmd, dir_rows[i].angle, dir_rows[i].heading,
                    dir_rows[i].point_range, dir_rows[i].qdeg, dir_rows[i].now};
            typed_res = '{dir_rows[i].exp_found, dir_rows[i].exp_range};
            send_request(req, dir_rows[i].typed, typed_res);
        end

        for (int phase = 1; phase <= NUM_PHASES; phase++)
        begin
            settle_block();
            case (phase)
                1:
                begin
                    write_reg(REG_MIN_RANGE, 16'd0);
                    write_reg(REG_MAX_RANGE, 16'hFFFF);
                    write_reg(REG_MAX_AGE,   16'hFFFF);
                    write_reg(REG_TOLERANCE, 16'hFFFF);
                end
                2:
                begin
                    write_reg(REG_MIN_RANGE, 16'hFFFF);
                    write_reg(REG_MAX_RANGE, 16'd0);
                    write_reg(REG_MAX_AGE,   16'd0);
                    write_reg(REG_TOLERANCE, 16'd0);
                end
                3:
                begin
                    write_reg(REG_TOLERANCE, RST_TOLERANCE);
                    write_reg(REG_MAX_AGE,   RST_MAX_AGE);
                    write_reg(REG_MAX_RANGE, RST_MAX_RANGE);
                    write_reg(REG_MIN_RANGE, RST_MIN_RANGE);
                end
                default:
                begin
                    write_reg(REG_MIN_RANGE, 16'($urandom_range(0, 500)));
                    write_reg(REG_MAX_RANGE, 16'($urandom_range(1000, 65535)));
                    write_reg(REG_MAX_AGE,   16'($urandom_range(1, 5000)));
                    write_reg(REG_TOLERANCE, 16'($urandom_range(0, 200)));
                end
            endcase
            @(negedge clk);
            cfg_valid = 1'b0;
            pick_base_range();
            repeat (RAND_PER_PHASE)
            begin
                build_request(req);
                send_request(req, PREDICTED, '0);
            end
        end

        settle_block();
        if (!failed && expected_reads.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/labsr_pkg.sv
rtl/core/labsr_mem.sv
rtl/core/labsr_bin_map.sv
rtl/core/labsr_ctrl.sv
rtl/core/lidar_angle_bin_store_robust_read.sv
bench/lidar_angle_bin_store_robust_read_tb.sv
